/* hdl/anim_seq_pkg.sv */
// shared item types and codes of the animation step sequencer
package anim_seq_pkg;

  localparam int SEQUENCES = 16;
  localparam int MAX_STEPS = 16;

  localparam logic [2:0] MODE_TICK      = 3'd0;
  localparam logic [2:0] MODE_START     = 3'd1;
  localparam logic [2:0] MODE_STOP      = 3'd2;
  localparam logic [2:0] MODE_CANCEL    = 3'd3;
  localparam logic [2:0] MODE_WR_DUR    = 3'd4;
  localparam logic [2:0] MODE_WR_SEQ    = 3'd5;

  localparam logic [1:0] EV_WAYPOINT = 2'd0;
  localparam logic [1:0] EV_END      = 2'd1;
  localparam logic [1:0] EV_BEGIN    = 2'd2;
  localparam logic [1:0] EV_DONE     = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  player_index;
    logic [3:0]  sequence_id;
    logic [3:0]  step_index;
    logic [15:0] duration_ticks;
    logic [4:0]  step_total;
    logic        run_once;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [1:0]  player_index_res;
    logic [3:0]  sequence_id_res;
    logic [3:0]  step_index_res;
    logic [15:0] fraction;
    logic        busy_any;
    logic        last;
  } out_item_t;

endpackage

/* hdl/animation_step_sequencer.sv */
// animation step sequencer: player walk, shared serial divider, result buffer
//
// Table writes (step duration, sequence descriptor) are done as the item is taken; stop,
// cancel and start pass through S_CMD and S_FIN. A tick walks over the players in use, one
// at a time: an idle player is skipped in S_TK_RD, a busy one passes S_TK_CHK and then
// S_BEGIN or S_DONE when its step ends, and S_DIV when it emits a waypoint, because the
// Q0.16 fraction comes from a restoring divider that resolves one quotient bit per cycle.
// Results of an item are collected in a buffer and then delivered one at a time through
// S_DRAIN and S_LOAD, so that busy_any and last reflect the state after the whole item.
// The block takes no new item until the last result has
// been loaded into the output register.
module animation_step_sequencer
  import anim_seq_pkg::*;
#(
  parameter int PLAYERS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0] cfg_data
);

  localparam int PIW       = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;
  localparam int PCW       = $clog2(PLAYERS + 1);
  localparam int RES_DEPTH = 3 * PLAYERS;
  localparam int BW        = $clog2(RES_DEPTH);
  localparam int CW        = $clog2(RES_DEPTH + 1);
  localparam int SIW       = $clog2(SEQUENCES);
  localparam int STW       = $clog2(MAX_STEPS);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CMD    = 10'b0000000010,
    S_TK_RD  = 10'b0000000100,
    S_TK_CHK = 10'b0000001000,
    S_DIV    = 10'b0000010000,
    S_DONE   = 10'b0000100000,
    S_BEGIN  = 10'b0001000000,
    S_FIN    = 10'b0010000000,
    S_DRAIN  = 10'b0100000000,
    S_LOAD   = 10'b1000000000
  } state_t;

  state_t st_r, st_nxt;

  logic [2:0] cfg_r;
  in_item_t   in_q_r;

  // sequence tables
  logic [4:0]  seq_len_r  [SEQUENCES];
  logic        seq_once_r [SEQUENCES];
  logic [15:0] dur_mem    [SEQUENCES * MAX_STEPS];
  logic [15:0] dur_q_r;

  // player state
  logic        busy_r [PLAYERS];
  logic [3:0]  seq_r  [PLAYERS];
  logic [3:0]  step_r [PLAYERS];
  logic [15:0] el_r   [PLAYERS];
  logic        stop_r [PLAYERS];
  logic        canc_r [PLAYERS];
  logic        qv_r   [PLAYERS];
  logic [3:0]  qs_r   [PLAYERS];

  logic [PCW-1:0] pc_r;
  logic [PCW-1:0] lim;
  logic [PIW-1:0] idx;

  // divider
  logic [16:0] rem_r;
  logic [15:0] quo_r;
  logic [4:0]  dcnt_r;
  logic [16:0] rem_sh;
  logic        q_bit;

  // result buffer
  out_item_t buf_mem [RES_DEPTH];
  out_item_t buf_q_r;
  logic [CW-1:0] wcnt_r;
  logic [CW-1:0] rd_r;
  logic          buf_we;
  out_item_t     buf_wd;
  out_item_t     ld_item;
  logic          act_r;
  logic          act;

  logic          in_acc;
  logic          out_free;
  logic [15:0]   el_inc;
  logic [4:0]    nst;
  logic          wrap;
  logic          finish;
  logic          wp_path;
  logic [1:0]    pres;
  logic          cmd_ok;
  logic [4:0]    cnt_sat;

  assign in_ready  = (st_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    if (32'(cfg_r) > PLAYERS) begin
      lim = PCW'(PLAYERS);
    end else begin
      lim = PCW'(cfg_r);
    end
  end

  assign idx     = (st_r == S_CMD) ? PIW'(in_q_r.player_index) : pc_r[PIW-1:0];
  assign pres    = 2'(idx);
  assign cmd_ok  = (32'(in_q_r.player_index) < PLAYERS);
  assign el_inc  = (el_r[idx] == 16'hFFFF) ? 16'hFFFF : el_r[idx] + 16'd1;
  assign nst     = {1'b0, step_r[idx]} + 5'd1;
  assign wrap    = (nst >= seq_len_r[seq_r[idx]]);
  assign finish  = seq_once_r[seq_r[idx]] || stop_r[idx];
  assign wp_path = (el_r[idx] < dur_q_r) && !canc_r[idx];
  assign rem_sh  = {rem_r[15:0], 1'b0};
  assign q_bit   = (rem_sh >= {1'b0, dur_q_r});
  assign cnt_sat = (32'(in_data.step_total) > MAX_STEPS) ? 5'(MAX_STEPS) : in_data.step_total;

  always_comb begin
    act = 1'b0;
    for (int i = 0; i < PLAYERS; i++) begin
      if ((i < 32'(lim)) && busy_r[i]) begin
        act = 1'b1;
      end
    end
  end

  // next state and buffer push
  always_comb begin
    st_nxt = st_r;
    buf_we = 1'b0;
    buf_wd = '0;
    buf_wd.player_index_res = pres;
    buf_wd.sequence_id_res  = seq_r[idx];
    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.mode == MODE_TICK) begin
            st_nxt = S_TK_RD;
          end else if (in_data.mode == MODE_START || in_data.mode == MODE_STOP ||
                       in_data.mode == MODE_CANCEL) begin
            st_nxt = S_CMD;
          end
        end
      end
      S_CMD: begin
        if (in_q_r.mode == MODE_START && cmd_ok && !busy_r[idx]) begin
          buf_we = 1'b1;
          buf_wd.event_res       = EV_BEGIN;
          buf_wd.sequence_id_res = in_q_r.sequence_id;
          buf_wd.step_index_res  = 4'd0;
        end
        st_nxt = S_FIN;
      end
      S_TK_RD: begin
        if (pc_r >= lim) begin
          st_nxt = S_FIN;
        end else if (busy_r[idx]) begin
          st_nxt = S_TK_CHK;
        end
      end
      S_TK_CHK: begin
        if (wp_path) begin
          st_nxt = S_DIV;
        end else begin
          buf_we = 1'b1;
          buf_wd.event_res      = EV_END;
          buf_wd.step_index_res = step_r[idx];
          st_nxt = (wrap && finish) ? S_DONE : S_BEGIN;
        end
      end
      S_DIV: begin
        if (dcnt_r == 5'd1) begin
          buf_we = 1'b1;
          buf_wd.event_res      = EV_WAYPOINT;
          buf_wd.step_index_res = step_r[idx];
          buf_wd.fraction       = {quo_r[14:0], q_bit};
          st_nxt = S_TK_RD;
        end
      end
      S_DONE: begin
        buf_we = 1'b1;
        buf_wd.event_res      = EV_DONE;
        buf_wd.step_index_res = 4'd0;
        st_nxt = qv_r[idx] ? S_BEGIN : S_TK_RD;
      end
      S_BEGIN: begin
        buf_we = 1'b1;
        buf_wd.event_res      = EV_BEGIN;
        buf_wd.step_index_res = step_r[idx];
        st_nxt = S_TK_RD;
      end
      S_FIN: begin
        st_nxt = (wcnt_r == '0) ? S_IDLE : S_DRAIN;
      end
      S_DRAIN: begin
        if (out_free) begin
          st_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        st_nxt = (rd_r + CW'(1) == wcnt_r) ? S_IDLE : S_DRAIN;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cfg_r  <= '0;
      pc_r   <= '0;
      wcnt_r <= '0;
      rd_r   <= '0;
      act_r  <= 1'b0;
      dcnt_r <= '0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
      if (buf_we) begin
        wcnt_r <= wcnt_r + CW'(1);
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          pc_r <= '0;
        end
        S_TK_RD: begin
          if (pc_r < lim && !busy_r[idx]) begin
            pc_r <= pc_r + PCW'(1);
          end
        end
        S_TK_CHK: begin
          if (wp_path) begin
            rem_r  <= {1'b0, el_r[idx]};
            quo_r  <= '0;
            dcnt_r <= 5'd16;
          end
        end
        S_DIV: begin
          rem_r  <= q_bit ? rem_sh - {1'b0, dur_q_r} : rem_sh;
          quo_r  <= {quo_r[14:0], q_bit};
          dcnt_r <= dcnt_r - 5'd1;
          if (dcnt_r == 5'd1) begin
            pc_r <= pc_r + PCW'(1);
          end
        end
        S_DONE: begin
          if (!qv_r[idx]) begin
            pc_r <= pc_r + PCW'(1);
          end
        end
        S_BEGIN: begin
          pc_r <= pc_r + PCW'(1);
        end
        S_FIN: begin
          act_r <= act;
          rd_r  <= '0;
        end
        S_LOAD: begin
          out_valid <= 1'b1;
          rd_r      <= rd_r + CW'(1);
          if (rd_r + CW'(1) == wcnt_r) begin
            wcnt_r <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    ld_item          = buf_q_r;
    ld_item.busy_any = act_r;
    ld_item.last     = (rd_r + CW'(1) == wcnt_r);
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (st_r == S_LOAD) begin
      out_data <= ld_item;
    end
  end

  // result buffer memory
  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[wcnt_r[BW-1:0]] <= buf_wd;
    end
    if (st_r == S_DRAIN && out_free) begin
      buf_q_r <= buf_mem[rd_r[BW-1:0]];
    end
  end

  // tables and latched item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_q_r <= in_data;
      if (in_data.mode == MODE_WR_DUR) begin
        dur_mem[{in_data.sequence_id[SIW-1:0], in_data.step_index[STW-1:0]}] <=
          in_data.duration_ticks;
      end
      if (in_data.mode == MODE_WR_SEQ) begin
        seq_len_r[in_data.sequence_id[SIW-1:0]]  <= cnt_sat;
        seq_once_r[in_data.sequence_id[SIW-1:0]] <= in_data.run_once;
      end
    end
    if (st_r == S_TK_RD) begin
      dur_q_r <= dur_mem[{seq_r[idx][SIW-1:0], step_r[idx][STW-1:0]}];
    end
  end

  // per player state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PLAYERS; i++) begin
        busy_r[i] <= 1'b0;
        seq_r[i]  <= '0;
        step_r[i] <= '0;
        el_r[i]   <= '0;
        stop_r[i] <= 1'b0;
        canc_r[i] <= 1'b0;
        qv_r[i]   <= 1'b0;
        qs_r[i]   <= '0;
      end
    end else begin
      case (st_r)
        S_CMD: begin
          if (cmd_ok) begin
            if (in_q_r.mode == MODE_START) begin
              if (busy_r[idx]) begin
                stop_r[idx] <= 1'b1;
                qv_r[idx]   <= 1'b1;
                qs_r[idx]   <= in_q_r.sequence_id;
              end else begin
                busy_r[idx] <= 1'b1;
                seq_r[idx]  <= in_q_r.sequence_id;
                step_r[idx] <= '0;
                el_r[idx]   <= '0;
                stop_r[idx] <= 1'b0;
                canc_r[idx] <= 1'b0;
              end
            end else if (in_q_r.mode == MODE_STOP) begin
              stop_r[idx] <= 1'b1;
            end else begin
              qv_r[idx]   <= 1'b0;
              stop_r[idx] <= 1'b1;
              canc_r[idx] <= 1'b1;
            end
          end
        end
        S_TK_RD: begin
          if (pc_r < lim && busy_r[idx]) begin
            el_r[idx] <= el_inc;
          end
        end
        S_TK_CHK: begin
          if (!wp_path) begin
            el_r[idx] <= '0;
            if (wrap && finish) begin
              busy_r[idx] <= 1'b0;
              stop_r[idx] <= 1'b0;
              canc_r[idx] <= 1'b0;
              step_r[idx] <= '0;
            end else if (wrap) begin
              step_r[idx] <= '0;
            end else begin
              step_r[idx] <= nst[3:0];
            end
          end
        end
        S_DONE: begin
          if (qv_r[idx]) begin
            seq_r[idx]  <= qs_r[idx];
            qv_r[idx]   <= 1'b0;
            busy_r[idx] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTH
  // divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV) |-> (rem_r < {1'b0, dur_q_r}))
    else $error("divider remainder out of range");

  // buffer never overfills
  a_buf_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(wcnt_r) <= RES_DEPTH))
    else $error("result buffer overflow");

  // output register is free whenever a result is loaded
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_LOAD) |-> !out_valid)
    else $error("result loaded over a pending item");

  // a new item is only taken once the buffer is empty
  a_in_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (wcnt_r == '0))
    else $error("item taken with results pending");
`endif

endmodule

/* verif/animation_step_sequencer_tb.sv */
// self-checking testbench of the animation step sequencer: random and directed items, scoreboard
module animation_step_sequencer_tb;
  import anim_seq_pkg::*;

  localparam int NUM_PLAYERS   = 4;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 3000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [2:0] cfg_data = '0;

  animation_step_sequencer #(.PLAYERS(NUM_PLAYERS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  in_item_t  pending_items[$];
  out_item_t expected_events[$];
  out_item_t new_events[$];

  int send_idle = 0;
  int recv_idle = 0;
  int cycle_count = 0;
  int fail_count = 0;
  int items_accepted = 0;
  int events_checked = 0;
  int settings_used = 0;
  bit pressure_phase = 1'b0;
  bit pressure_done = 1'b0;
  int hold_count = 0;

  // predictor copy of the block state
  logic [2:0]  players_cfg;
  logic [4:0]  tbl_len[16];
  logic        tbl_once[16];
  logic [15:0] tbl_dur[256];
  logic        pl_busy[4];
  logic [3:0]  pl_seq[4];
  logic [3:0]  pl_step[4];
  logic [15:0] pl_elapsed[4];
  logic        pl_stopping[4];
  logic        pl_cancel[4];
  logic        q_valid[4];
  logic [3:0]  q_seq[4];

  // generator view of which table entries have been written
  bit          gen_desc_ok[16];
  int          gen_len[16];
  bit          gen_dur_ok[256];

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int players_advanced();
    return (players_cfg > NUM_PLAYERS) ? NUM_PLAYERS : int'(players_cfg);
  endfunction

  function automatic void push_event(logic [1:0] ev, int p, logic [3:0] s, logic [3:0] st,
                                     logic [15:0] frac);
    out_item_t e;
    e = '0;
    e.event_res = ev;
    e.player_index_res = p[1:0];
    e.sequence_id_res = s;
    e.step_index_res = st;
    e.fraction = frac;
    new_events.push_back(e);
  endfunction

  function automatic void advance_player(int p);
    logic [3:0]  s;
    logic [3:0]  st;
    logic [15:0] dur;
    logic [31:0] num;
    logic [31:0] frac;
    int          nxt;
    if (!pl_busy[p]) return;
    s = pl_seq[p];
    st = pl_step[p];
    if (pl_elapsed[p] != 16'hFFFF) pl_elapsed[p] = pl_elapsed[p] + 16'd1;
    dur = tbl_dur[{s, st}];
    if (pl_elapsed[p] < dur && !pl_cancel[p]) begin
      num = {pl_elapsed[p], 16'h0000};
      frac = num / {16'h0000, dur};
      push_event(EV_WAYPOINT, p, s, st, frac[15:0]);
      return;
    end
    push_event(EV_END, p, s, st, 16'h0);
    pl_elapsed[p] = '0;
    nxt = int'(st) + 1;
    if (nxt >= int'(tbl_len[s])) begin
      nxt = 0;
      if (tbl_once[s] || pl_stopping[p]) begin
        pl_busy[p] = 1'b0;
        pl_stopping[p] = 1'b0;
        pl_cancel[p] = 1'b0;
        pl_step[p] = '0;
        push_event(EV_DONE, p, s, 4'd0, 16'h0);
        if (!q_valid[p]) return;
        s = q_seq[p];
        q_valid[p] = 1'b0;
        pl_seq[p] = s;
        pl_busy[p] = 1'b1;
      end
    end
    pl_step[p] = nxt[3:0];
    push_event(EV_BEGIN, p, s, nxt[3:0], 16'h0);
  endfunction

  function automatic void predict_events(in_item_t it);
    int  p;
    bit  act;
    out_item_t e;
    new_events.delete();
    p = int'(it.player_index);
    case (it.mode)
      MODE_TICK: begin
        for (int i = 0; i < players_advanced(); i++) advance_player(i);
      end
      MODE_START: begin
        if (pl_busy[p]) begin
          pl_stopping[p] = 1'b1;
          q_valid[p] = 1'b1;
          q_seq[p] = it.sequence_id;
        end else begin
          pl_busy[p] = 1'b1;
          pl_seq[p] = it.sequence_id;
          pl_step[p] = '0;
          pl_elapsed[p] = '0;
          pl_stopping[p] = 1'b0;
          pl_cancel[p] = 1'b0;
          push_event(EV_BEGIN, p, it.sequence_id, 4'd0, 16'h0);
        end
      end
      MODE_STOP: pl_stopping[p] = 1'b1;
      MODE_CANCEL: begin
        q_valid[p] = 1'b0;
        pl_stopping[p] = 1'b1;
        pl_cancel[p] = 1'b1;
      end
      MODE_WR_DUR: tbl_dur[{it.sequence_id, it.step_index}] = it.duration_ticks;
      MODE_WR_SEQ: begin
        tbl_len[it.sequence_id] = (it.step_total > 5'd16) ? 5'd16 : it.step_total;
        tbl_once[it.sequence_id] = it.run_once;
      end
      default: ;
    endcase
    act = 1'b0;
    for (int i = 0; i < players_advanced(); i++)
      if (pl_busy[i]) act = 1'b1;
    for (int k = 0; k < new_events.size(); k++) begin
      e = new_events[k];
      e.busy_any = act;
      e.last = (k == new_events.size() - 1);
      expected_events.push_back(e);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_events(in_data);
        items_accepted <= items_accepted + 1;
      end
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_valid <= 1'b1;
        in_data <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the block backs up
  always @(posedge clk) begin
    if (pressure_phase && !pressure_done) begin
      if (hold_count == HOLD_CYCLES) pressure_done <= 1'b1;
      else hold_count <= hold_count + 1;
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    out_item_t exp_ev;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        events_checked <= events_checked + 1;
        if (expected_events.size() == 0) begin
          $error("unexpected result item %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_ev = expected_events.pop_front();
          if (out_data !== exp_ev) begin
            fail_count <= fail_count + 1;
            if (out_data.event_res !== exp_ev.event_res)
              $error("event_res: expected %0d, got %0d", exp_ev.event_res, out_data.event_res);
            if (out_data.player_index_res !== exp_ev.player_index_res)
              $error("player_index_res: expected %0d, got %0d",
                     exp_ev.player_index_res, out_data.player_index_res);
            if (out_data.sequence_id_res !== exp_ev.sequence_id_res)
              $error("sequence_id_res: expected %0d, got %0d",
                     exp_ev.sequence_id_res, out_data.sequence_id_res);
            if (out_data.step_index_res !== exp_ev.step_index_res)
              $error("step_index_res: expected %0d, got %0d",
                     exp_ev.step_index_res, out_data.step_index_res);
            if (out_data.fraction !== exp_ev.fraction)
              $error("fraction: expected %0d, got %0d", exp_ev.fraction, out_data.fraction);
            if (out_data.busy_any !== exp_ev.busy_any)
              $error("busy_any: expected %0d, got %0d", exp_ev.busy_any, out_data.busy_any);
            if (out_data.last !== exp_ev.last)
              $error("last: expected %0d, got %0d", exp_ev.last, out_data.last);
          end
        end
      end
      out_ready <= !(pressure_phase && !pressure_done) && ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic bit seq_ready(int s);
    if (!gen_desc_ok[s]) return 1'b0;
    for (int i = 0; i < gen_len[s]; i++)
      if (!gen_dur_ok[s * 16 + i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic in_item_t random_fields();
    in_item_t it;
    it.mode = 3'($urandom);
    it.player_index = 2'($urandom);
    it.sequence_id = 4'($urandom);
    it.step_index = 4'($urandom);
    it.duration_ticks = 16'($urandom);
    it.step_total = 5'($urandom);
    it.run_once = 1'($urandom);
    return it;
  endfunction

  function automatic void queue_item(in_item_t it);
    int len;
    if (it.mode == MODE_WR_DUR) gen_dur_ok[{it.sequence_id, it.step_index}] = 1'b1;
    if (it.mode == MODE_WR_SEQ) begin
      len = (it.step_total == 0) ? 1 : ((it.step_total > 16) ? 16 : int'(it.step_total));
      gen_desc_ok[it.sequence_id] = 1'b1;
      gen_len[it.sequence_id] = len;
    end
    pending_items.push_back(it);
  endfunction

  function automatic logic [15:0] pick_duration();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(5));
    if (r < 90) return 16'($urandom_range(40, 6));
    return 16'($urandom);
  endfunction

  function automatic void queue_duration(int s, int st, logic [15:0] d);
    in_item_t it;
    it = random_fields();
    it.mode = MODE_WR_DUR;
    it.sequence_id = s[3:0];
    it.step_index = st[3:0];
    it.duration_ticks = d;
    queue_item(it);
  endfunction

  function automatic void queue_random(int count);
    in_item_t it;
    int r;
    int len;
    int s;
    int tries;
    for (int n = 0; n < count; n++) begin
      it = random_fields();
      r = $urandom_range(99);
      if (r < 45) begin
        it.mode = MODE_TICK;
      end else if (r < 65) begin
        it.mode = MODE_START;
        tries = 0;
        do begin
          s = $urandom_range(15);
          tries++;
        end while (!seq_ready(s) && tries < 64);
        if (!seq_ready(s)) it.mode = MODE_TICK;
        it.sequence_id = s[3:0];
      end else if (r < 72) begin
        it.mode = MODE_STOP;
      end else if (r < 77) begin
        it.mode = MODE_CANCEL;
      end else if (r < 89) begin
        it.mode = MODE_WR_DUR;
        it.duration_ticks = pick_duration();
      end else if (r < 97) begin
        it.mode = MODE_WR_SEQ;
        if ($urandom_range(99) >= 8) it.step_total = 5'($urandom_range(4));
        len = (it.step_total == 0) ? 1 : ((it.step_total > 16) ? 16 : int'(it.step_total));
        // fill missing slots first so no running player reads an unwritten duration
        for (int i = 0; i < len; i++)
          if (!gen_dur_ok[{it.sequence_id, 4'(i)}])
            queue_duration(int'(it.sequence_id), i, pick_duration());
      end else begin
        it.mode = 3'($urandom_range(7, 6));
      end
      queue_item(it);
    end
  endfunction

  function automatic void queue_directed();
    in_item_t it;
    queue_duration(0, 0, 16'd0);
    queue_duration(0, 1, 16'd3);
    queue_duration(0, 2, 16'hFFFF);
    queue_duration(15, 0, 16'd2);
    it = random_fields(); it.mode = MODE_WR_SEQ; it.sequence_id = 4'd0;
    it.step_total = 5'd3; it.run_once = 1'b1; queue_item(it);
    it = random_fields(); it.mode = MODE_WR_SEQ; it.sequence_id = 4'd15;
    it.step_total = 5'd0; it.run_once = 1'b0; queue_item(it);
    it = random_fields(); it.mode = MODE_START; it.player_index = 2'd0;
    it.sequence_id = 4'd0; queue_item(it);
    // zero-duration step, waypoints, then the longest step
    for (int i = 0; i < 5; i++) begin
      it = random_fields(); it.mode = MODE_TICK; queue_item(it);
    end
    it = random_fields(); it.mode = MODE_CANCEL; it.player_index = 2'd0; queue_item(it);
    it = random_fields(); it.mode = MODE_TICK; queue_item(it);
    // stop and cancel on idle players 1 and 2; a start later clears player 2
    it = random_fields(); it.mode = MODE_STOP; it.player_index = 2'd1; queue_item(it);
    it = random_fields(); it.mode = MODE_CANCEL; it.player_index = 2'd2; queue_item(it);
    it = random_fields(); it.mode = MODE_START; it.player_index = 2'd2;
    it.sequence_id = 4'd15; queue_item(it);
    it = random_fields(); it.mode = MODE_START; it.player_index = 2'd2;
    it.sequence_id = 4'd0; queue_item(it);
    for (int i = 0; i < 2; i++) begin
      it = random_fields(); it.mode = MODE_TICK; queue_item(it);
    end
    it = random_fields(); it.mode = 3'd6; queue_item(it);
    it = random_fields(); it.mode = 3'd7; queue_item(it);
    it = random_fields(); it.mode = MODE_START; it.player_index = 2'd3;
    it.sequence_id = 4'd15; queue_item(it);
    it = random_fields(); it.mode = MODE_TICK; queue_item(it);
  endfunction

  task automatic write_players(input logic [2:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    players_cfg = v;
    settings_used++;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_events.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [2:0] cfg_plan[6];
    cfg_plan = '{3'd4, 3'd7, 3'd2, 3'd0, 3'd3, 3'd4};
    players_cfg = '0;
    for (int i = 0; i < 4; i++) begin
      pl_busy[i] = 0; pl_seq[i] = 0; pl_step[i] = 0; pl_elapsed[i] = 0;
      pl_stopping[i] = 0; pl_cancel[i] = 0; q_valid[i] = 0; q_seq[i] = 0;
    end
    for (int i = 0; i < 16; i++) begin
      tbl_len[i] = 0; tbl_once[i] = 0; gen_desc_ok[i] = 0; gen_len[i] = 0;
    end
    for (int i = 0; i < 256; i++) begin
      tbl_dur[i] = 0; gen_dur_ok[i] = 0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      write_players(cfg_plan[ph]);
      case (ph % 3)
        0: begin send_idle = 38; recv_idle = 83; end
        1: begin send_idle = 83; recv_idle = 38; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (ph == 5) pressure_phase = 1'b1;
      if (ph == 0) begin
        queue_directed();
        queue_random(45);
      end else begin
        queue_random(57);
      end
      drain();
    end
    $display("items accepted: %0d, result items checked: %0d, player settings: %0d",
             items_accepted, events_checked, settings_used);
    if (fail_count == 0 && expected_events.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/anim_seq_pkg.sv
hdl/animation_step_sequencer.sv
verif/animation_step_sequencer_tb.sv
